// ===== hw/rtl/rcfe_pkg.sv =====
// ----------------------------------------------------------------------------
// rcfe_pkg
// Shared types, register codes and constants of the RC channel frame encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rcfe_pkg;

	// Field and register widths
	localparam int unsigned ValW    = 12;  // raw channel value and input bounds
	localparam int unsigned OutW    = 11;  // frame value and output bounds
	localparam int unsigned ByteW   = 8;
	localparam int unsigned CfgIdxW = 4;
	localparam int unsigned CfgDatW = 12;
	localparam int unsigned AccW    = 18;  // packing accumulator
	localparam int unsigned HeldW   = 5;   // bits held in the accumulator
	localparam int unsigned ChCntW  = 4;   // channel position in the frame

	// Quotient magnitude: |v - in_min| * |out_max - out_min| fits in this many bits
	localparam int unsigned ProdW    = ValW + OutW;
	localparam int unsigned DivSteps = ProdW;
	localparam int unsigned DivCntW  = 5;

	localparam logic [ChCntW-1:0] LastChannel = ChCntW'(15);

	// Register indexes
	localparam logic [CfgIdxW-1:0] RegInMin    = CfgIdxW'(0);
	localparam logic [CfgIdxW-1:0] RegInMax    = CfgIdxW'(1);
	localparam logic [CfgIdxW-1:0] RegOutMin   = CfgIdxW'(2);
	localparam logic [CfgIdxW-1:0] RegOutMax   = CfgIdxW'(3);
	localparam logic [CfgIdxW-1:0] RegHeader   = CfgIdxW'(4);
	localparam logic [CfgIdxW-1:0] RegFooter   = CfgIdxW'(5);
	localparam logic [CfgIdxW-1:0] RegLossMask = CfgIdxW'(6);
	localparam logic [CfgIdxW-1:0] RegFsMask   = CfgIdxW'(7);

	// Register reset values
	localparam logic [ValW-1:0]  RstInMin    = ValW'(1000);
	localparam logic [ValW-1:0]  RstInMax    = ValW'(2000);
	localparam logic [OutW-1:0]  RstOutMin   = OutW'(173);
	localparam logic [OutW-1:0]  RstOutMax   = OutW'(1811);
	localparam logic [ByteW-1:0] RstHeader   = 8'h0F;
	localparam logic [ByteW-1:0] RstFooter   = 8'h00;
	localparam logic [ByteW-1:0] RstLossMask = 8'h04;
	localparam logic [ByteW-1:0] RstFsMask   = 8'h08;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_PACK,
		ST_HDR,
		ST_DATA,
		ST_FLAGS,
		ST_FOOT
	} state_t;

	// Commands from the sequencer to the datapath
	typedef struct packed {
		logic accept;      // latch the channel request
		logic mul;         // form product and divisor, start the divider
		logic div_step;    // one quotient bit
		logic pack;        // rescale and merge into the accumulator
		logic load_hdr;
		logic load_data;
		logic load_flags;
		logic load_foot;
		logic finish;      // advance channel position
	} cmd_t;

	// Status from the datapath to the sequencer
	typedef struct packed {
		logic div_done;
		logic first;       // channel 0 of the frame
		logic last;        // channel 15 of the frame
		logic data_avail;  // a full byte sits in the accumulator
		logic slot_free;   // output register can take a byte
	} sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rcfe_ctrl.sv =====
// ----------------------------------------------------------------------------
// rcfe_ctrl
// Sequencer: walks each channel through multiply, divide, pack and byte output.
// ----------------------------------------------------------------------------
`default_nettype none

module rcfe_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          chan_valid,
	output logic               chan_ready,
	input  wire rcfe_pkg::sts_t sts,
	output rcfe_pkg::cmd_t     cmd
);

	rcfe_pkg::state_t state_q;
	rcfe_pkg::state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rcfe_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		chan_ready = 1'b0;
		unique case (state_q)
			rcfe_pkg::ST_IDLE: begin
				chan_ready = 1'b1;
				if (chan_valid) begin
					cmd.accept = 1'b1;
					state_d    = rcfe_pkg::ST_MUL;
				end
			end
			rcfe_pkg::ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = rcfe_pkg::ST_DIV;
			end
			rcfe_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) begin
					state_d = rcfe_pkg::ST_PACK;
				end
			end
			rcfe_pkg::ST_PACK: begin
				cmd.pack = 1'b1;
				state_d  = sts.first ? rcfe_pkg::ST_HDR : rcfe_pkg::ST_DATA;
			end
			rcfe_pkg::ST_HDR: begin
				if (sts.slot_free) begin
					cmd.load_hdr = 1'b1;
					state_d      = rcfe_pkg::ST_DATA;
				end
			end
			rcfe_pkg::ST_DATA: begin
				// drain full bytes, then close the channel or the frame
				if (sts.data_avail) begin
					cmd.load_data = sts.slot_free;
				end else if (sts.last) begin
					state_d = rcfe_pkg::ST_FLAGS;
				end else begin
					cmd.finish = 1'b1;
					state_d    = rcfe_pkg::ST_IDLE;
				end
			end
			rcfe_pkg::ST_FLAGS: begin
				if (sts.slot_free) begin
					cmd.load_flags = 1'b1;
					state_d        = rcfe_pkg::ST_FOOT;
				end
			end
			rcfe_pkg::ST_FOOT: begin
				if (sts.slot_free) begin
					cmd.load_foot = 1'b1;
					cmd.finish    = 1'b1;
					state_d       = rcfe_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rcfe_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/rcfe_datapath.sv =====
// ----------------------------------------------------------------------------
// rcfe_datapath
// Configuration registers, rescale multiplier, bit-serial divider, bit packer
// and the output byte register.
// ----------------------------------------------------------------------------
`default_nettype none

module rcfe_datapath (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// configuration
	input  wire logic                                cfg_wr,
	input  wire logic [rcfe_pkg::CfgIdxW-1:0]        cfg_index,
	input  wire logic [rcfe_pkg::CfgDatW-1:0]        cfg_data,
	// channel request payload
	input  wire logic [rcfe_pkg::ValW-1:0]           channel_value,
	input  wire logic                                signal_loss,
	input  wire logic                                failsafe,
	// frame byte channel
	output logic                                     frm_valid,
	input  wire logic                                frm_ready,
	output logic [rcfe_pkg::ByteW-1:0]               frame_byte,
	output logic                                     frame_end,
	// sequencer link
	input  wire rcfe_pkg::cmd_t                      cmd,
	output rcfe_pkg::sts_t                           sts
);

	localparam int unsigned ValW  = rcfe_pkg::ValW;
	localparam int unsigned OutW  = rcfe_pkg::OutW;
	localparam int unsigned ByteW = rcfe_pkg::ByteW;
	localparam int unsigned ProdW = rcfe_pkg::ProdW;
	localparam int unsigned AccW  = rcfe_pkg::AccW;
	localparam int unsigned HeldW = rcfe_pkg::HeldW;

	// Configuration registers
	logic [ValW-1:0]  in_min_q, in_max_q;
	logic [OutW-1:0]  out_min_q, out_max_q;
	logic [ByteW-1:0] header_q, footer_q, loss_mask_q, fs_mask_q;

	// Latched request
	logic [ValW-1:0] val_q;
	logic            loss_q, fs_q;

	// Divider
	logic [ProdW-1:0]                 quo_q;
	logic [ValW-1:0]                  rem_q;
	logic [ValW-1:0]                  den_q;
	logic                             neg_q;
	logic                             eq_q;
	logic [rcfe_pkg::DivCntW-1:0]     cnt_q;

	// Packer
	logic [AccW-1:0]                  acc_q;
	logic [HeldW-1:0]                 held_q;
	logic [rcfe_pkg::ChCntW-1:0]      ch_q;

	// Output register
	logic             out_valid_q;
	logic [ByteW-1:0] out_byte_q;
	logic             out_end_q;

	// Operand differences and magnitudes
	logic [ValW:0]    dv, dd;
	logic [OutW:0]    dout;
	logic [ValW-1:0]  dv_mag, dd_mag;
	logic [OutW-1:0]  dout_mag;
	logic [ProdW-1:0] prod;

	always_comb begin
		dv       = {1'b0, val_q} - {1'b0, in_min_q};
		dd       = {1'b0, in_max_q} - {1'b0, in_min_q};
		dout     = {1'b0, out_max_q} - {1'b0, out_min_q};
		dv_mag   = dv[ValW] ? ValW'(-dv) : dv[ValW-1:0];
		dd_mag   = dd[ValW] ? ValW'(-dd) : dd[ValW-1:0];
		dout_mag = dout[OutW] ? OutW'(-dout) : dout[OutW-1:0];
		prod     = ProdW'(dv_mag) * ProdW'(dout_mag);
	end

	// Restoring divide step
	logic [ValW+1:0] trial;
	logic            trial_ok;

	always_comb begin
		trial    = {1'b0, rem_q, quo_q[ProdW-1]} - {2'b00, den_q};
		trial_ok = !trial[ValW+1];
	end

	// Rescaled value and its merge into the accumulator
	logic [OutW-1:0] q_low, q_signed, rescaled;
	logic [AccW-1:0] acc_base, acc_merge;
	logic [HeldW-1:0] held_base;

	always_comb begin
		q_low     = quo_q[OutW-1:0];
		q_signed  = neg_q ? OutW'(-q_low) : q_low;
		rescaled  = eq_q ? out_min_q : OutW'(out_min_q + q_signed);
		acc_base  = sts.first ? '0 : acc_q;
		held_base = sts.first ? '0 : held_q;
		acc_merge = acc_base | (AccW'(rescaled) << held_base[2:0]);
	end

	logic [ByteW-1:0] flags;
	assign flags = (loss_q ? loss_mask_q : '0) | (fs_q ? fs_mask_q : '0);

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_min_q    <= rcfe_pkg::RstInMin;
			in_max_q    <= rcfe_pkg::RstInMax;
			out_min_q   <= rcfe_pkg::RstOutMin;
			out_max_q   <= rcfe_pkg::RstOutMax;
			header_q    <= rcfe_pkg::RstHeader;
			footer_q    <= rcfe_pkg::RstFooter;
			loss_mask_q <= rcfe_pkg::RstLossMask;
			fs_mask_q   <= rcfe_pkg::RstFsMask;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				rcfe_pkg::RegInMin:    in_min_q    <= cfg_data[ValW-1:0];
				rcfe_pkg::RegInMax:    in_max_q    <= cfg_data[ValW-1:0];
				rcfe_pkg::RegOutMin:   out_min_q   <= cfg_data[OutW-1:0];
				rcfe_pkg::RegOutMax:   out_max_q   <= cfg_data[OutW-1:0];
				rcfe_pkg::RegHeader:   header_q    <= cfg_data[ByteW-1:0];
				rcfe_pkg::RegFooter:   footer_q    <= cfg_data[ByteW-1:0];
				rcfe_pkg::RegLossMask: loss_mask_q <= cfg_data[ByteW-1:0];
				rcfe_pkg::RegFsMask:   fs_mask_q   <= cfg_data[ByteW-1:0];
				default: ;
			endcase
		end
	end

	// Latch request, set up and run the divider
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			val_q  <= channel_value;
			loss_q <= signal_loss;
			fs_q   <= failsafe;
		end
		if (cmd.mul) begin
			quo_q <= prod;
			rem_q <= '0;
			den_q <= dd_mag;
			neg_q <= dv[ValW] ^ dout[OutW] ^ dd[ValW];
			eq_q  <= (dd == '0);
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[ProdW-2:0], trial_ok};
			rem_q <= trial_ok ? trial[ValW-1:0] : {rem_q[ValW-2:0], quo_q[ProdW-1]};
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// Pack bits, drain bytes, advance channel position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			held_q <= '0;
			ch_q   <= '0;
		end else begin
			if (cmd.pack) begin
				acc_q  <= acc_merge;
				held_q <= held_base + HeldW'(OutW);
			end else if (cmd.load_data) begin
				acc_q  <= acc_q >> ByteW;
				held_q <= held_q - HeldW'(ByteW);
			end else if (cmd.finish && sts.last) begin
				acc_q  <= '0;
				held_q <= '0;
			end
			if (cmd.finish) begin
				ch_q <= ch_q + 1'b1;
			end
		end
	end

	// Output register: hold until taken, refill when free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_hdr || cmd.load_data || cmd.load_flags || cmd.load_foot) begin
			out_valid_q <= 1'b1;
		end else if (frm_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_hdr) begin
			out_byte_q <= header_q;
			out_end_q  <= 1'b0;
		end else if (cmd.load_data) begin
			out_byte_q <= acc_q[ByteW-1:0];
			out_end_q  <= 1'b0;
		end else if (cmd.load_flags) begin
			out_byte_q <= flags;
			out_end_q  <= 1'b0;
		end else if (cmd.load_foot) begin
			out_byte_q <= footer_q;
			out_end_q  <= 1'b1;
		end
	end

	// Status to the sequencer
	always_comb begin
		sts.div_done   = (cnt_q == rcfe_pkg::DivCntW'(rcfe_pkg::DivSteps - 1));
		sts.first      = (ch_q == '0);
		sts.last       = (ch_q == rcfe_pkg::LastChannel);
		sts.data_avail = (held_q >= HeldW'(ByteW));
		sts.slot_free  = !out_valid_q || frm_ready;
	end

	assign frm_valid  = out_valid_q;
	assign frame_byte = out_byte_q;
	assign frame_end  = out_end_q;

endmodule

`default_nettype wire

// ===== hw/rtl/rc_channel_frame_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// rc_channel_frame_encoder_unit
// Encodes 16 rescaled 11-bit RC channels into a 25-byte serial frame.
// ----------------------------------------------------------------------------
// Usage:
//   Channel requests arrive on chan_valid/chan_ready, one per channel, in
//   order 0..15. Each value is rescaled with the configured bounds, packed
//   LSB first, and every completed byte leaves on frm_valid/frm_ready as
//   frame_byte. Channel 0 sends the header first; channel 15 sends the flags
//   byte (from signal_loss and failsafe of that request) and the footer,
//   which carries frame_end.
//   Configuration is written on cfg_valid/cfg_ready (always ready), by index;
//   the user must write it only while the unit is idle; the unit does not check.
// Sequence:
//   A channel passes through the multiply, the bit-serial divider (one quotient
//   bit per cycle), the pack step, the byte output (1 to 4 bytes, each waiting
//   for a free output register), the close of the channel and the idle state
//   that accepts the next request.
// Reset clears the channel position, the accumulator and the output register
//   and loads the default bounds, header 0x0F, footer 0x00, masks 0x04/0x08.
// A stalled receiver holds the current byte; the sequencer waits for the
//   output register to free before loading the next one. A new channel is
//   accepted while the last byte of the previous one still waits.
// ----------------------------------------------------------------------------
`default_nettype none

module rc_channel_frame_encoder_unit (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// configuration
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [rcfe_pkg::CfgIdxW-1:0] cfg_index,
	input  wire logic [rcfe_pkg::CfgDatW-1:0] cfg_data,
	// channel requests
	input  wire logic                         chan_valid,
	output logic                              chan_ready,
	input  wire logic [rcfe_pkg::ValW-1:0]    channel_value,
	input  wire logic                         signal_loss,
	input  wire logic                         failsafe,
	// frame bytes
	output logic                              frm_valid,
	input  wire logic                         frm_ready,
	output logic [rcfe_pkg::ByteW-1:0]        frame_byte,
	output logic                              frame_end
);

	rcfe_pkg::cmd_t cmd;
	rcfe_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	rcfe_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.chan_valid (chan_valid),
		.chan_ready (chan_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	rcfe_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr        (cfg_valid && cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.channel_value (channel_value),
		.signal_loss   (signal_loss),
		.failsafe      (failsafe),
		.frm_valid     (frm_valid),
		.frm_ready     (frm_ready),
		.frame_byte    (frame_byte),
		.frame_end     (frame_end),
		.cmd           (cmd),
		.sts           (sts)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/rcfe_checker.sv =====
// ----------------------------------------------------------------------------
// rcfe_checker
// Port-level checks of the frame encoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rcfe_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         chan_valid,
	input wire logic                         chan_ready,
	input wire logic                         frm_valid,
	input wire logic                         frm_ready,
	input wire logic [rcfe_pkg::ByteW-1:0]   frame_byte,
	input wire logic                         frame_end
);

	logic chan_acc;
	assign chan_acc = chan_valid && chan_ready;

	// A stalled byte holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		frm_valid && !frm_ready |=> frm_valid && $stable(frame_byte) && $stable(frame_end))
		else $error("frame byte changed while stalled");

	// One channel at a time: busy for the multiply and the first divide steps after a request
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		chan_acc |=> !chan_ready ##1 !chan_ready ##1 !chan_ready)
		else $error("channel request taken during divide");

	// No byte comes out during the multiply and the first divide step after a request
	a_no_early_byte: assert property (@(posedge clk) disable iff (!arst_n)
		chan_acc |=> !$rose(frm_valid) ##1 !$rose(frm_valid))
		else $error("frame byte appeared too early");

	// The footer ends a channel, so the unit is ready again right after it loads
	a_ready_after_footer: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(frm_valid) && frame_end |-> chan_ready)
		else $error("unit not idle after footer");

endmodule

bind rc_channel_frame_encoder_unit rcfe_checker u_rcfe_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.chan_valid (chan_valid),
	.chan_ready (chan_ready),
	.frm_valid  (frm_valid),
	.frm_ready  (frm_ready),
	.frame_byte (frame_byte),
	.frame_end  (frame_end)
);

`default_nettype wire

// ===== dv/rc_channel_frame_encoder_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_channel_frame_encoder_unit_tb
// Sends channel requests through the frame encoder under changing bounds,
// header, footer and flag masks, predicts every frame byte from its own
// rescale-and-pack model and checks the bytes in order, with random idling
// on both sides and one long receiver hold that backs up the input.
// ----------------------------------------------------------------------------

module rc_channel_frame_encoder_unit_tb;

	localparam int unsigned ValW    = rcfe_pkg::ValW;
	localparam int unsigned OutW    = rcfe_pkg::OutW;
	localparam int unsigned ByteW   = rcfe_pkg::ByteW;
	localparam int unsigned CfgIdxW = rcfe_pkg::CfgIdxW;
	localparam int unsigned CfgDatW = rcfe_pkg::CfgDatW;
	localparam int unsigned AccW    = rcfe_pkg::AccW;
	localparam int unsigned HeldW   = rcfe_pkg::HeldW;
	localparam int unsigned ChCntW  = rcfe_pkg::ChCntW;

	localparam int unsigned SettleCycles = 40;   // sequencer return to idle
	localparam int unsigned DrainCycles  = 60;
	localparam int unsigned HoldAtByte   = 60;
	localparam int unsigned HoldCycles   = 300;
	localparam int unsigned RandPhases   = 8;
	localparam int unsigned PhaseChans   = 36;
	localparam int unsigned MaxCfgIndex  = (1 << CfgIdxW) - 1;

	typedef enum int {
		MODE_NOMINAL,
		MODE_WIDE,
		MODE_EDGE,
		MODE_REVERSED
	} cfg_mode_t;

	typedef struct packed {
		logic [ValW-1:0] value;
		logic            loss;
		logic            fs;
	} chan_req_t;

	typedef struct packed {
		logic [ByteW-1:0] data;
		logic             last;
	} frm_byte_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CfgIdxW-1:0]  cfg_index = '0;
	logic [CfgDatW-1:0]  cfg_data  = '0;
	logic                chan_valid = 1'b0;
	logic                chan_ready;
	logic [ValW-1:0]     channel_value = '0;
	logic                signal_loss = 1'b0;
	logic                failsafe    = 1'b0;
	logic                frm_valid;
	logic                frm_ready = 1'b0;
	logic [ByteW-1:0]    frame_byte;
	logic                frame_end;

	// Encoder mirror: bounds, frame codes and packing state
	logic [ValW-1:0]   map_in_lo  = rcfe_pkg::RstInMin;
	logic [ValW-1:0]   map_in_hi  = rcfe_pkg::RstInMax;
	logic [OutW-1:0]   map_out_lo = rcfe_pkg::RstOutMin;
	logic [OutW-1:0]   map_out_hi = rcfe_pkg::RstOutMax;
	logic [ByteW-1:0]  hdr_code   = rcfe_pkg::RstHeader;
	logic [ByteW-1:0]  ftr_code   = rcfe_pkg::RstFooter;
	logic [ByteW-1:0]  loss_bits  = rcfe_pkg::RstLossMask;
	logic [ByteW-1:0]  fs_bits    = rcfe_pkg::RstFsMask;
	logic [ChCntW-1:0] slot_idx   = '0;
	logic [AccW-1:0]   pend_bits  = '0;
	logic [HeldW-1:0]  pend_cnt   = '0;

	chan_req_t   channel_queue[$];
	frm_byte_t   expected_bytes[$];
	chan_req_t   next_req;
	int unsigned chans_sent   = 0;
	int unsigned chans_taken  = 0;
	int unsigned bytes_seen   = 0;
	int unsigned errors       = 0;
	int unsigned tx_gap       = 0;
	int unsigned rx_gap       = 0;
	int unsigned hold_left    = 0;
	logic        hold_taken   = 1'b0;
	logic        quiet        = 1'b0;

	rc_channel_frame_encoder_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.chan_valid    (chan_valid),
		.chan_ready    (chan_ready),
		.channel_value (channel_value),
		.signal_loss   (signal_loss),
		.failsafe      (failsafe),
		.frm_valid     (frm_valid),
		.frm_ready     (frm_ready),
		.frame_byte    (frame_byte),
		.frame_end     (frame_end)
	);

	always #1 clk = ~clk;

	// Linear map onto the 11-bit frame range, truncating division, wrapping result
	function automatic logic [OutW-1:0] scale_channel(input logic [ValW-1:0] raw);
		longint span_in;
		longint scaled;
		span_in = longint'(map_in_hi) - longint'(map_in_lo);
		if (span_in == 0) begin
			scaled = longint'(map_out_lo);
		end else begin
			scaled = longint'(map_out_lo) + ((longint'(raw) - longint'(map_in_lo)) *
				(longint'(map_out_hi) - longint'(map_out_lo))) / span_in;
		end
		return scaled[OutW-1:0];
	endfunction

	function automatic void expect_byte(input logic [ByteW-1:0] data, input logic last);
		frm_byte_t b;
		b.data = data;
		b.last = last;
		expected_bytes.push_back(b);
	endfunction

	// Pack one channel and queue the bytes it completes
	function automatic void encode_channel(input logic [ValW-1:0] raw, input logic loss,
			input logic fs);
		logic [OutW-1:0]  mapped;
		logic [ByteW-1:0] flags;
		mapped = scale_channel(raw);
		if (slot_idx == '0) begin
			expect_byte(hdr_code, 1'b0);
			pend_bits = '0;
			pend_cnt  = '0;
		end
		pend_bits = pend_bits | (AccW'(mapped) << pend_cnt[2:0]);
		pend_cnt  = pend_cnt + HeldW'(OutW);
		while (pend_cnt >= HeldW'(ByteW)) begin
			expect_byte(pend_bits[ByteW-1:0], 1'b0);
			pend_bits = pend_bits >> ByteW;
			pend_cnt  = pend_cnt - HeldW'(ByteW);
		end
		if (slot_idx == rcfe_pkg::LastChannel) begin
			flags = (loss ? loss_bits : '0) | (fs ? fs_bits : '0);
			expect_byte(flags, 1'b0);
			expect_byte(ftr_code, 1'b1);
			pend_bits = '0;
			pend_cnt  = '0;
		end
		slot_idx = slot_idx + 1'b1;
	endfunction

	// Channel driver: predict on each accepted request, then offer the next one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_valid    <= 1'b0;
			channel_value <= '0;
			signal_loss   <= 1'b0;
			failsafe      <= 1'b0;
			tx_gap = 0;
		end else begin
			if (chan_valid && chan_ready) begin
				encode_channel(channel_value, signal_loss, failsafe);
				chans_taken++;
			end
			if (!chan_valid || chan_ready) begin
				if (tx_gap != 0) begin
					tx_gap--;
					chan_valid <= 1'b0;
				end else if (!quiet && $urandom_range(0, 5) == 0) begin
					tx_gap = $urandom_range(1, 8) - 1;
					chan_valid <= 1'b0;
				end else if (channel_queue.size() != 0) begin
					next_req = channel_queue.pop_front();
					chan_valid    <= 1'b1;
					channel_value <= next_req.value;
					signal_loss   <= next_req.loss;
					failsafe      <= next_req.fs;
				end else begin
					chan_valid <= 1'b0;
				end
			end
		end
	end

	// Frame monitor: check each byte against the oldest prediction, stall at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frm_ready <= 1'b0;
			rx_gap    = 0;
			hold_left = 0;
		end else begin
			if (frm_valid && frm_ready) begin
				if (expected_bytes.size() == 0) begin
					$display("%0t: frame byte %02h end %0b with none expected",
						$time, frame_byte, frame_end);
					errors++;
				end else begin
					frm_byte_t exp_b;
					exp_b = expected_bytes.pop_front();
					if (frame_byte !== exp_b.data) begin
						$display("%0t: frame_byte expected %02h actual %02h",
							$time, exp_b.data, frame_byte);
						errors++;
					end
					if (frame_end !== exp_b.last) begin
						$display("%0t: frame_end expected %0b actual %0b",
							$time, exp_b.last, frame_end);
						errors++;
					end
				end
				bytes_seen++;
			end
			// hold off once for long enough that the channel input backs up
			if (!hold_taken && bytes_seen >= HoldAtByte) begin
				hold_taken = 1'b1;
				hold_left  = HoldCycles;
			end
			if (hold_left != 0) begin
				hold_left--;
				frm_ready <= 1'b0;
			end else if (rx_gap != 0) begin
				rx_gap--;
				frm_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				rx_gap = $urandom_range(1, 8) - 1;
				frm_ready <= 1'b0;
			end else begin
				frm_ready <= 1'b1;
			end
		end
	end

	// Write one register; call at a rising edge, returns at the accepting edge
	task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			rcfe_pkg::RegInMin:    map_in_lo  = data[ValW-1:0];
			rcfe_pkg::RegInMax:    map_in_hi  = data[ValW-1:0];
			rcfe_pkg::RegOutMin:   map_out_lo = data[OutW-1:0];
			rcfe_pkg::RegOutMax:   map_out_hi = data[OutW-1:0];
			rcfe_pkg::RegHeader:   hdr_code   = data[ByteW-1:0];
			rcfe_pkg::RegFooter:   ftr_code   = data[ByteW-1:0];
			rcfe_pkg::RegLossMask: loss_bits  = data[ByteW-1:0];
			rcfe_pkg::RegFsMask:   fs_bits    = data[ByteW-1:0];
			default: ;
		endcase
	endtask

	task automatic program_regs(input cfg_mode_t mode);
		logic [CfgDatW-1:0] data;
		logic               nominal;
		nominal = (mode == MODE_NOMINAL);
		for (int i = int'(rcfe_pkg::RegInMin); i <= int'(rcfe_pkg::RegFsMask); i++) begin
			if (mode == MODE_WIDE) begin
				data = CfgDatW'($urandom);
			end else if (mode == MODE_EDGE) begin
				data = $urandom_range(0, 1) ? '1 : '0;
			end else begin
				case (CfgIdxW'(i))
					rcfe_pkg::RegInMin:  data = CfgDatW'(nominal ?
						$urandom_range(800, 1200) : $urandom_range(2000, 4095));
					rcfe_pkg::RegInMax:  data = CfgDatW'(nominal ?
						$urandom_range(1800, 2200) : $urandom_range(0, 1999));
					rcfe_pkg::RegOutMin: data = CfgDatW'(nominal ?
						$urandom_range(0, 300) : $urandom_range(1024, 2047));
					rcfe_pkg::RegOutMax: data = CfgDatW'(nominal ?
						$urandom_range(1700, 2047) : $urandom_range(0, 1023));
					default:   data = CfgDatW'($urandom_range(0, 255));
				endcase
			end
			cfg_write(CfgIdxW'(i), data);
		end
		// unmapped index must leave every register alone
		if ($urandom_range(0, 1))
			cfg_write(CfgIdxW'($urandom_range(rcfe_pkg::RegFsMask + 1, MaxCfgIndex)),
				CfgDatW'($urandom));
		cfg_valid <= 1'b0;
	endtask

	task automatic queue_channel(input logic [ValW-1:0] value, input logic loss, input logic fs);
		chan_req_t r;
		r.value = value;
		r.loss  = loss;
		r.fs    = fs;
		channel_queue.push_back(r);
		chans_sent++;
	endtask

	// Mostly values between the bounds, some anywhere, some at the field ends
	task automatic queue_random_channels(input int unsigned count);
		int unsigned     lo;
		int unsigned     hi;
		int unsigned     pick;
		logic [ValW-1:0] value;
		lo = 32'((map_in_lo < map_in_hi) ? map_in_lo : map_in_hi);
		hi = 32'((map_in_lo < map_in_hi) ? map_in_hi : map_in_lo);
		for (int unsigned n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 70)
				value = ValW'($urandom_range(lo, hi));
			else if (pick < 85)
				value = ValW'($urandom);
			else
				value = $urandom_range(0, 1) ? '1 : '0;
			queue_channel(value, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		end
	endtask

	task automatic wait_drained;
		while (!(chans_taken == chans_sent && expected_bytes.size() == 0))
			@(posedge clk);
	endtask

	// Run limit
	initial begin
		#500us;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		logic [ValW-1:0] dir_vals[16];
		dir_vals = '{12'd0, 12'hFFF, 12'd1000, 12'd2000, 12'd1500, 12'd999, 12'd2001,
			12'd1001, 12'd1999, 12'h555, 12'hAAA, 12'd2047, 12'd2048, 12'd500,
			12'd3000, 12'd1234};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// one full frame at reset settings: field ends, in-range and wrapping values
		for (int i = 0; i < 16; i++)
			queue_channel(dir_vals[i], i[0], i[1]);
		wait_drained();

		// equal input bounds, reversed and masked output bounds, unmapped index
		repeat (SettleCycles) @(posedge clk);
		cfg_write(rcfe_pkg::RegInMin, 12'd2048);
		cfg_write(rcfe_pkg::RegInMax, 12'd2048);
		cfg_write(rcfe_pkg::RegOutMin, 12'hFFF);
		cfg_write(rcfe_pkg::RegOutMax, 12'h000);
		cfg_write(rcfe_pkg::RegHeader, 12'hAFF);
		cfg_write(rcfe_pkg::RegFooter, 12'h5A5);
		cfg_write(rcfe_pkg::RegLossMask, 12'hFFF);
		cfg_write(rcfe_pkg::RegFsMask, 12'h000);
		cfg_write(CfgIdxW'(rcfe_pkg::RegFsMask + 1), 12'hFFF);
		cfg_valid <= 1'b0;
		queue_channel(12'd0, 1'b1, 1'b1);
		queue_channel(12'hFFF, 1'b0, 1'b1);
		queue_channel(12'd2048, 1'b1, 1'b0);
		for (int i = 0; i < 6; i++)
			queue_channel(ValW'($urandom), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)));
		wait_drained();

		// random phases, new settings each time; no idling in two of them
		for (int unsigned p = 0; p < RandPhases; p++) begin
			repeat (SettleCycles) @(posedge clk);
			quiet <= (p == 3 || p == RandPhases - 1);
			program_regs(cfg_mode_t'(p % 4));
			queue_random_channels(PhaseChans);
			wait_drained();
		end

		repeat (DrainCycles) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
